[hdl/bic_pkg.sv]
// Package for the banked interrupt controller: word types, command codes,
// register offsets and masks. No dependencies.
package bic_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  localparam logic [5:0] OFF_BASIC_PEND = 6'd0;
  localparam logic [5:0] OFF_PEND1      = 6'd1;
  localparam logic [5:0] OFF_PEND2      = 6'd2;
  localparam logic [5:0] OFF_EN1        = 6'd4;
  localparam logic [5:0] OFF_EN2        = 6'd5;
  localparam logic [5:0] OFF_BASIC_EN   = 6'd6;
  localparam logic [5:0] OFF_DIS1       = 6'd7;
  localparam logic [5:0] OFF_DIS2       = 6'd8;
  localparam logic [5:0] OFF_BASIC_DIS  = 6'd9;

  localparam logic [7:0] LOCAL_MASK = 8'hFF;
  localparam logic [6:0] MAX_IRQ    = 7'd71;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  reg_offset;
    logic [31:0] write_data;
    logic [63:0] gpu_sources;
    logic [7:0]  arm_sources;
  } bic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_error;
    logic        irq_line;
    logic [6:0]  next_irq;
    logic        next_irq_valid;
  } bic_out_t;

  typedef struct packed {
    logic [31:0] bank1;
    logic [31:0] bank2;
    logic [7:0]  local_pend;
  } bic_pend_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_error;
  } bic_acc_t;

endpackage

[hdl/banked_interrupt_controller.sv]
// Banked interrupt controller top level: input register, register/pending
// logic, priority encoder and result register. Depends on bic_pkg, bic_regs, bic_prio.
// An input register and a result register lie between input accept and result accept.
// Throughput: one word per cycle, sustained while out_ready stays high.
// Reset: empties both pipeline registers and clears all enables.
module banked_interrupt_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bic_pkg::bic_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output bic_pkg::bic_out_t out_word
);
  import bic_pkg::*;

  bic_in_t   item;
  logic      item_valid;
  logic      advance;
  bic_acc_t  acc;
  bic_pend_t pend;
  logic [6:0] nirq;
  logic       nirq_valid;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) item_valid <= in_valid;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (in_valid && in_ready) item <= in_word;
    if (advance) begin
      out_word.read_data      <= acc.read_data;
      out_word.bus_error      <= acc.bus_error;
      out_word.irq_line       <= nirq_valid;
      out_word.next_irq       <= nirq;
      out_word.next_irq_valid <= nirq_valid;
    end
  end

  bic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .acc     (acc),
    .pend    (pend)
  );

  bic_prio u_prio (
    .pend           (pend),
    .next_irq       (nirq),
    .next_irq_valid (nirq_valid)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (item_valid && out_valid && !out_ready))
    else $error("input stalled while pipeline has room");

  a_irq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.next_irq_valid |-> out_word.next_irq <= MAX_IRQ)
    else $error("next_irq out of range");

  a_irq_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.next_irq_valid |-> out_word.next_irq == 7'd0 && !out_word.irq_line)
    else $error("idle interrupt number not zero");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.bus_error |-> out_word.read_data == 32'd0)
    else $error("bus error with nonzero read data");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !item_valid)
    else $error("pipeline not empty after reset");

endmodule

[hdl/bic_regs.sv]
// Enable registers, bus register decode and pending computation.
// Depends on bic_pkg.
module bic_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  bic_pkg::bic_in_t item,
  output bic_pkg::bic_acc_t acc,
  output bic_pkg::bic_pend_t pend
);
  import bic_pkg::*;

  logic [63:0] gpu_en;
  logic [63:0] gpu_en_next;
  logic [7:0]  arm_en;
  logic [7:0]  arm_en_next;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [7:0]  loc;

  assign p1  = item.gpu_sources[31:0] & gpu_en[31:0];
  assign p2  = item.gpu_sources[63:32] & gpu_en[63:32];
  assign loc = item.arm_sources & arm_en;

  always_comb begin
    logic rd;
    rd = (item.command == CMD_READ);
    gpu_en_next   = gpu_en;
    arm_en_next   = arm_en;
    acc.read_data = '0;
    acc.bus_error = 1'b0;
    if (item.command == CMD_READ || item.command == CMD_WRITE) begin
      case (item.reg_offset)
        OFF_BASIC_PEND: begin
          if (rd) acc.read_data = {22'd0, |p2, |p1, loc & LOCAL_MASK};
        end
        OFF_PEND1: begin
          if (rd) acc.read_data = p1;
        end
        OFF_PEND2: begin
          if (rd) acc.read_data = p2;
        end
        OFF_EN1: begin
          if (rd) acc.read_data = gpu_en[31:0];
          else gpu_en_next[31:0] = gpu_en[31:0] | item.write_data;
        end
        OFF_DIS1: begin
          if (rd) acc.read_data = gpu_en[31:0];
          else gpu_en_next[31:0] = gpu_en[31:0] & ~item.write_data;
        end
        OFF_EN2: begin
          if (rd) acc.read_data = gpu_en[63:32];
          else gpu_en_next[63:32] = gpu_en[63:32] | item.write_data;
        end
        OFF_DIS2: begin
          if (rd) acc.read_data = gpu_en[63:32];
          else gpu_en_next[63:32] = gpu_en[63:32] & ~item.write_data;
        end
        OFF_BASIC_EN: begin
          if (rd) acc.read_data = {24'd0, arm_en};
          else arm_en_next = (arm_en | item.write_data[7:0]) & LOCAL_MASK;
        end
        OFF_BASIC_DIS: begin
          if (rd) acc.read_data = {24'd0, arm_en};
          else arm_en_next = arm_en & ~item.write_data[7:0] & LOCAL_MASK;
        end
        default: begin
          acc.bus_error = 1'b1;
        end
      endcase
    end
  end

  assign pend.bank1      = item.gpu_sources[31:0] & gpu_en_next[31:0];
  assign pend.bank2      = item.gpu_sources[63:32] & gpu_en_next[63:32];
  assign pend.local_pend = item.arm_sources & arm_en_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gpu_en <= '0;
      arm_en <= '0;
    end else if (advance) begin
      gpu_en <= gpu_en_next;
      arm_en <= arm_en_next;
    end
  end

endmodule

[hdl/bic_prio.sv]
// Priority encoder: local sources, then bank 1, then bank 2, lowest bit first.
// Depends on bic_pkg.
module bic_prio (
  input  bic_pkg::bic_pend_t pend,
  output logic [6:0]         next_irq,
  output logic               next_irq_valid
);
  import bic_pkg::*;

  logic [31:0] iso1;
  logic [31:0] iso2;
  logic [7:0]  iso_loc;
  logic [4:0]  idx1;
  logic [4:0]  idx2;
  logic [2:0]  idx_loc;

  // isolate lowest set bit, then encode the one-hot word
  assign iso1    = pend.bank1 & (~pend.bank1 + 32'd1);
  assign iso2    = pend.bank2 & (~pend.bank2 + 32'd1);
  assign iso_loc = pend.local_pend & (~pend.local_pend + 8'd1);

  always_comb begin
    idx1    = '0;
    idx2    = '0;
    idx_loc = '0;
    for (int i = 0; i < 32; i++) begin
      if (iso1[i]) idx1 = idx1 | 5'(i);
      if (iso2[i]) idx2 = idx2 | 5'(i);
    end
    for (int i = 0; i < 8; i++) begin
      if (iso_loc[i]) idx_loc = idx_loc | 3'(i);
    end
  end

  always_comb begin
    next_irq       = '0;
    next_irq_valid = 1'b1;
    if (pend.local_pend != '0) next_irq = {4'b1000, idx_loc};
    else if (pend.bank1 != '0) next_irq = {2'b00, idx1};
    else if (pend.bank2 != '0) next_irq = {2'b01, idx2};
    else next_irq_valid = 1'b0;
  end

endmodule
